/* rtl/kvst_pkg.sv */
`default_nettype none
package kvst_pkg;

   localparam int KEY_W   = 16;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

   // mode codes
   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

/* rtl/kvst_ram.sv */
`default_nettype none
module kvst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* rtl/kvst_ctrl.sv */
`default_nettype none
module kvst_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire kvst_pkg::stat_type stat,
   output kvst_pkg::cmd_type       cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOOKUP = 2'd1;
   localparam logic [1:0] S_DONE   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   always_comb begin
      req_tready = (state_ff == S_IDLE) || ((state_ff == S_DONE) && stat.out_free);
      accept = req_tvalid && req_tready;
      cmd.capture = accept;
      cmd.lookup  = (state_ff == S_LOOKUP);
      cmd.load    = (state_ff == S_DONE) && stat.out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            // result leaves for the output register, next word may enter alongside
            if (stat.out_free) state_in = accept ? S_LOOKUP : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/kvst_datapath.sv */
`default_nettype none
module kvst_datapath #(
   parameter int SLOTS = 16,
   parameter int IDX_W = 4
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire kvst_pkg::cmd_type               cmd,
   output kvst_pkg::stat_type                   stat,
   input  wire logic                            req_mode,
   input  wire logic [kvst_pkg::KEY_W-1:0]      req_key,
   input  wire logic [kvst_pkg::VALUE_W-1:0]    req_value,
   output logic                                 rsp_valid_ff,
   input  wire logic                            rsp_ready,
   output logic [kvst_pkg::STAT_W-1:0]          rsp_status_ff,
   output logic [kvst_pkg::VALUE_W-1:0]         rsp_value_ff
);

   logic                           mode_ff, mode_in;
   logic [kvst_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [kvst_pkg::VALUE_W-1:0]   wval_ff, wval_in;
   logic [SLOTS-1:0]               valid_ff, valid_in;
   logic [kvst_pkg::KEY_W-1:0]     slot_key_ff [SLOTS];
   logic [kvst_pkg::KEY_W-1:0]     slot_key_in [SLOTS];
   logic [kvst_pkg::STAT_W-1:0]    status_ff, status_in;
   logic                           rd_hit_ff, rd_hit_in;
   logic                           rsp_valid_in;
   logic [kvst_pkg::STAT_W-1:0]    rsp_status_in;
   logic [kvst_pkg::VALUE_W-1:0]   rsp_value_in;

   logic [SLOTS-1:0]               match;
   logic                           hit;
   logic [IDX_W-1:0]               hit_idx;
   logic                           free_any;
   logic [IDX_W-1:0]               free_idx;

   logic                           ram_we;
   logic [IDX_W-1:0]               ram_waddr;
   logic                           ram_re;
   logic [kvst_pkg::VALUE_W-1:0]   ram_rdata;

   // parallel key compare and lowest-index pick
   always_comb begin
      hit      = 1'b0;
      hit_idx  = '0;
      free_any = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (slot_key_ff[i] == key_ff);
         if (match[i]) begin
            hit     = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      key_in        = key_ff;
      wval_in       = wval_ff;
      valid_in      = valid_ff;
      slot_key_in   = slot_key_ff;
      status_in     = status_ff;
      rd_hit_in     = rd_hit_ff;
      ram_we        = 1'b0;
      ram_waddr     = hit_idx;
      ram_re        = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;

      if (cmd.capture) begin
         mode_in = req_mode;
         key_in  = req_key;
         wval_in = req_value;
      end

      if (cmd.lookup) begin
         rd_hit_in = 1'b0;
         status_in = kvst_pkg::ST_OK;
         if (mode_ff == kvst_pkg::MODE_WRITE) begin
            if (hit) begin
               ram_we = 1'b1;
            end else if (free_any) begin
               ram_we                = 1'b1;
               ram_waddr             = free_idx;
               slot_key_in[free_idx] = key_ff;
               valid_in[free_idx]    = 1'b1;
            end else begin
               status_in = kvst_pkg::ST_FULL;
            end
         end else begin
            if (hit) begin
               ram_re    = 1'b1;
               rd_hit_in = 1'b1;
            end else begin
               status_in = kvst_pkg::ST_NOT_FOUND;
            end
         end
      end

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_value_in  = rd_hit_ff ? ram_rdata : '0;
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   kvst_ram #(
      .WIDTH  (kvst_pkg::VALUE_W),
      .DEPTH  (SLOTS),
      .ADDR_W (IDX_W)
   ) u_value_ram (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (ram_waddr),
      .wr_data    (wval_ff),
      .rd_en      (ram_re),
      .rd_addr    (hit_idx),
      .rd_data_ff (ram_rdata)
   );

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      wval_ff       <= wval_in;
      slot_key_ff   <= slot_key_in;
      status_ff     <= status_in;
      rd_hit_ff     <= rd_hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/key_value_settings_table.sv */
`default_nettype none
// Small associative table of SLOTS entries, each a 16-bit key with a raw 32-bit value.
// A write word (tuser mode 1) updates the entry holding its key, or claims the lowest
// empty entry, and answers status 2 when no entry is left; a read word (mode 0) answers
// the stored value, or status 1 with zero data when the key is absent. Every request
// word gives exactly one response word. Each word passes through the parallel
// key compare with lowest-index pick and the value memory access, then through the
// registered memory read into the output register. The next word is taken in the same
// cycle as the response is loaded, so a new word enters as the last one leaves unless the
// response side stalls. Entries are never freed; reset empties the table at once.
module key_value_settings_table #(
   parameter int SLOTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // key [15:0], write_value [47:16]
   input  wire logic [0:0]  req_tuser,   // mode [0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // read_value [31:0]
   output logic [1:0]       rsp_tuser    // status [1:0]
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   kvst_pkg::cmd_type  cmd;
   kvst_pkg::stat_type stat;

   kvst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   kvst_datapath #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_mode      (req_tuser[0]),
      .req_key       (req_tdata[15:0]),
      .req_value     (req_tdata[47:16]),
      .rsp_valid_ff  (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_status_ff (rsp_tuser),
      .rsp_value_ff  (rsp_tdata)
   );

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none
module tb_top;

   localparam int SLOTS       = 16;
   localparam int RAND_WORDS  = 375;   // per phase
   localparam int HOLD_OFF    = 300;
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 10;

   typedef struct packed {
      logic [kvst_pkg::STAT_W-1:0]  status;
      logic [kvst_pkg::VALUE_W-1:0] value;
   } answer_type;

   class settings_scoreboard;
      logic                         slot_used  [SLOTS];
      logic [kvst_pkg::KEY_W-1:0]   slot_key   [SLOTS];
      logic [kvst_pkg::VALUE_W-1:0] slot_value [SLOTS];
      int                           used;
      answer_type                   pending_answers [$];
      int                           errors;
      int                           n_reads, n_writes, n_miss, n_full;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
         end
         used = 0;
         errors = 0;
         n_reads = 0;
         n_writes = 0;
         n_miss = 0;
         n_full = 0;
      endfunction

      // work out the answer to an accepted request word and update the table copy
      function void note_request(logic mode, logic [kvst_pkg::KEY_W-1:0] key,
                                 logic [kvst_pkg::VALUE_W-1:0] value);
         int         hit;
         int         spare;
         answer_type ans;
         hit = SLOTS;
         spare = SLOTS;
         for (int i = SLOTS - 1; i >= 0; i--) begin
            if (slot_used[i] && slot_key[i] == key) hit = i;
            if (!slot_used[i]) spare = i;
         end
         ans.status = kvst_pkg::ST_OK;
         ans.value = '0;
         if (mode == kvst_pkg::MODE_WRITE) begin
            n_writes++;
            if (hit == SLOTS && spare < SLOTS) begin
               hit = spare;
               slot_used[hit] = 1'b1;
               slot_key[hit] = key;
               used++;
            end
            if (hit < SLOTS) begin
               slot_value[hit] = value;
            end else begin
               ans.status = kvst_pkg::ST_FULL;
               n_full++;
            end
         end else begin
            n_reads++;
            if (hit < SLOTS) begin
               ans.value = slot_value[hit];
            end else begin
               ans.status = kvst_pkg::ST_NOT_FOUND;
               n_miss++;
            end
         end
         pending_answers.push_back(ans);
      endfunction

      function void check_response(logic [kvst_pkg::STAT_W-1:0] status,
                                   logic [kvst_pkg::VALUE_W-1:0] value);
         answer_type ans;
         if (pending_answers.size() == 0) begin
            $display("%0t: response word with none expected, status %0d data %h",
                     $time, status, value);
            errors++;
         end else begin
            ans = pending_answers.pop_front();
            if (status !== ans.status) begin
               $display("%0t: status expected %0d got %0d", $time, ans.status, status);
               errors++;
            end
            if (value !== ans.value) begin
               $display("%0t: data expected %h got %h", $time, ans.value, value);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;    // key [15:0], write_value [47:16]
   logic [0:0]  req_tuser;    // mode [0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // read_value [31:0]
   logic [1:0]  rsp_tuser;    // status [1:0]

   settings_scoreboard sb = new();
   int send_idle_pct;
   int recv_stall_pct;
   bit hold_off_go;
   int quiet;

   key_value_settings_table #(
      .SLOTS(SLOTS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response first, then any request word taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tuser, rsp_tdata);
         if (req_tvalid && req_tready) sb.note_request(req_tuser[0], req_tdata[15:0],
                                                       req_tdata[47:16]);
      end
   end

   initial begin
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("[key_value_settings_table] ERROR");
      $finish;
   end

   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_word(input logic mode, input logic [kvst_pkg::KEY_W-1:0] key,
                            input logic [kvst_pkg::VALUE_W-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {value, key};
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // mostly keys already held, now and then a fresh one so the table fills slowly
   task automatic send_random_word();
      logic                       mode;
      logic [kvst_pkg::KEY_W-1:0] key;
      int                         odds;
      mode = $urandom_range(0, 1) ? kvst_pkg::MODE_WRITE : kvst_pkg::MODE_READ;
      odds = (mode == kvst_pkg::MODE_WRITE) ? 24 : 8;
      if (sb.used > 0 && $urandom_range(0, odds - 1) != 0)
         key = sb.slot_key[$urandom_range(0, sb.used - 1)];
      else
         key = kvst_pkg::KEY_W'($urandom);
      send_word(mode, key, $urandom);
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_go = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, extreme keys and values, overwrite, read ignoring its data
      send_word(kvst_pkg::MODE_READ,  16'h0000, 32'h0000_0000);
      send_word(kvst_pkg::MODE_READ,  16'hFFFF, 32'hFFFF_FFFF);
      send_word(kvst_pkg::MODE_WRITE, 16'h0000, 32'h0000_0000);
      send_word(kvst_pkg::MODE_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
      send_word(kvst_pkg::MODE_READ,  16'h0000, 32'h0000_0000);
      send_word(kvst_pkg::MODE_READ,  16'hFFFF, 32'h0000_0000);
      send_word(kvst_pkg::MODE_WRITE, 16'h0000, 32'hFFFF_FFFF);
      send_word(kvst_pkg::MODE_READ,  16'h0000, 32'h0000_0000);
      send_word(kvst_pkg::MODE_WRITE, 16'hAAAA, 32'h5A5A_5A5A);
      send_word(kvst_pkg::MODE_WRITE, 16'h5555, 32'hA5A5_A5A5);
      send_word(kvst_pkg::MODE_READ,  16'hAAAA, 32'h0000_0000);
      send_word(kvst_pkg::MODE_READ,  16'h5555, 32'h0000_0000);
      send_word(kvst_pkg::MODE_WRITE, 16'h5555, 32'h1234_5678);
      send_word(kvst_pkg::MODE_READ,  16'h5555, 32'h0000_0000);
      send_word(kvst_pkg::MODE_READ,  16'h0001, 32'h0000_0000);
      send_word(kvst_pkg::MODE_READ,  16'hFFFF, 32'hDEAD_BEEF);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
               hold_off_go = 1'b1;
            end
            1: begin
               send_idle_pct = 75;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 75;
            end
            default: begin
               send_idle_pct = 6;
               recv_stall_pct = 6;
            end
         endcase
         repeat (RAND_WORDS) send_random_word();
      end
      req_tvalid <= 1'b0;

      while (sb.pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("run covered %0d reads (%0d misses) and %0d writes (%0d refused as full)",
               sb.n_reads, sb.n_miss, sb.n_writes, sb.n_full);
      $display("table ended with %0d of %0d entries in use, %0d mismatches",
               sb.used, SLOTS, sb.errors);
      if (sb.errors == 0) begin
         $display("[key_value_settings_table] OK");
      end else begin
         $display("[key_value_settings_table] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
